### rtl/cld_pkg.sv
// ============================================================================
// cld_pkg
// Shared types and constants of the credit-based dispatch block.
// ============================================================================
package cld_pkg;

    localparam int NUM_WORKERS_DEF = 16;
    localparam int QUEUE_DEPTH_DEF = 64;

    localparam int ACTION_W = 3;
    localparam int WORKER_W = 4;
    localparam int HANDLE_W = 16;
    localparam int ADDR_W   = 3;
    localparam int DATA_W   = 32;

    // Input action codes
    localparam logic [ACTION_W-1:0] ACT_CREDIT = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_EVENT  = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_STOP   = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_TERM   = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_CLEAR  = 3'd4;

    // Register index taken from paddr[2]
    localparam logic REG_LAX = 1'b0;

    typedef enum logic [2:0] {
        OP_CREDIT,
        OP_EVENT,
        OP_STOP,
        OP_TERM,
        OP_CLEAR
    } t_op;

    typedef enum logic [2:0] {
        KIND_ROUTE        = 3'd0,
        KIND_STOP         = 3'd1,
        KIND_TERM         = 3'd2,
        KIND_DISMISS_IDLE = 3'd3,
        KIND_DISMISS_STOP = 3'd4,
        KIND_ERR_IDLE     = 3'd5,
        KIND_OVERFLOW     = 3'd6
    } t_kind;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CREDIT,
        ST_BCAST
    } t_state;

    typedef struct packed {
        t_op                 op;
        logic [WORKER_W-1:0] worker;
        logic [HANDLE_W-1:0] handle;
    } t_cmd;

    typedef struct packed {
        t_kind               kind;
        logic [WORKER_W-1:0] dest;
        logic [HANDLE_W-1:0] handle;
        logic                can_accept;
        logic                last;
    } t_res;

endpackage

### rtl/cld_front.sv
// ============================================================================
// cld_front
// Input side: classifies items and queues commands for the back end.
// ============================================================================
module cld_front #(
    parameter int NUM_WORKERS = cld_pkg::NUM_WORKERS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_push,
    output logic                           o_full,
    input  logic [cld_pkg::ACTION_W-1:0]   i_action,
    input  logic [cld_pkg::WORKER_W-1:0]   i_worker,
    input  logic [cld_pkg::HANDLE_W-1:0]   i_event_handle,
    output cld_pkg::t_cmd                  o_cmd,
    output logic                           o_cmd_valid,
    input  logic                           i_cmd_ready
);
    import cld_pkg::*;

    t_cmd       r_q [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;
    logic       n_wr;
    logic       n_rd;
    logic [1:0] n_cnt;

    t_cmd       cmd_in;
    logic       keep;
    logic       do_wr;
    logic       do_rd;

    assign o_full      = (r_cnt == 2'd2);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rd];

    // Unknown actions and credits from out-of-range workers are dropped here
    always_comb begin
        keep           = 1'b1;
        cmd_in.worker  = i_worker;
        cmd_in.handle  = i_event_handle;
        cmd_in.op      = OP_CLEAR;
        unique case (i_action)
            ACT_CREDIT: begin
                cmd_in.op = OP_CREDIT;
                keep      = (7'(i_worker) < 7'(NUM_WORKERS));
            end
            ACT_EVENT: cmd_in.op = OP_EVENT;
            ACT_STOP:  cmd_in.op = OP_STOP;
            ACT_TERM:  cmd_in.op = OP_TERM;
            ACT_CLEAR: cmd_in.op = OP_CLEAR;
            default:   keep      = 1'b0;
        endcase
    end

    always_comb begin
        do_wr = i_push && !o_full && keep;
        do_rd = o_cmd_valid && i_cmd_ready;
        n_wr  = do_wr ? !r_wr : r_wr;
        n_rd  = do_rd ? !r_rd : r_rd;
        n_cnt = r_cnt + 2'(do_wr) - 2'(do_rd);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_q[r_wr] <= cmd_in;
        end
    end

endmodule

### rtl/cld_back.sv
// ============================================================================
// cld_back
// Execution side: ready-worker queue, registration, flags and broadcasts.
// ============================================================================
module cld_back #(
    parameter int NUM_WORKERS = cld_pkg::NUM_WORKERS_DEF,
    parameter int QUEUE_DEPTH = cld_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  cld_pkg::t_cmd i_cmd,
    input  logic          i_cmd_valid,
    output logic          o_cmd_ready,
    input  logic          i_lax,
    output cld_pkg::t_res o_res,
    output logic          o_res_valid,
    input  logic          i_res_ready
);
    import cld_pkg::*;

    // Only workers 0..15 can be named by the 4-bit index
    localparam int MASK_W = (NUM_WORKERS < 16) ? NUM_WORKERS : 16;
    localparam int WIDX_W = $clog2(MASK_W);
    localparam int PTR_W  = $clog2(QUEUE_DEPTH);
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);

    t_state              r_state, n_state;
    logic [PTR_W-1:0]    r_head, n_head;
    logic [PTR_W-1:0]    r_tail, n_tail;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [MASK_W-1:0]   r_mask, n_mask;
    logic                r_stop, n_stop;
    logic                r_term, n_term;
    logic [2:0]          r_pend, n_pend;      // {terminate, stop, overflow}
    logic [WORKER_W-1:0] r_wrk, n_wrk;
    logic [MASK_W-1:0]   r_bc_left, n_bc_left;
    t_kind               r_bc_kind, n_bc_kind;

    logic [WORKER_W-1:0] r_mem [QUEUE_DEPTH];
    logic [WORKER_W-1:0] r_rd_data;
    logic                r_byp_valid;
    logic [WORKER_W-1:0] r_byp_data;

    logic                mem_we;
    logic [WORKER_W-1:0] head_data;
    logic [WIDX_W-1:0]   widx;
    logic [WIDX_W-1:0]   bc_idx;
    logic                q_full;
    logic                fresh;

    function automatic logic [PTR_W-1:0] f_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        r = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
        return r;
    endfunction

    function automatic logic [WIDX_W-1:0] f_lowest(input logic [MASK_W-1:0] v);
        logic [WIDX_W-1:0] idx;
        idx = '0;
        for (int i = MASK_W - 1; i >= 0; i--) begin
            if (v[i]) begin
                idx = WIDX_W'(i);
            end
        end
        return idx;
    endfunction

    assign head_data = r_byp_valid ? r_byp_data : r_rd_data;
    assign widx      = i_cmd.worker[WIDX_W-1:0];
    assign bc_idx    = f_lowest(r_bc_left);
    assign q_full    = (r_count == CNT_W'(QUEUE_DEPTH));
    assign fresh     = !r_mask[widx];

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_tail      = r_tail;
        n_count     = r_count;
        n_mask      = r_mask;
        n_stop      = r_stop;
        n_term      = r_term;
        n_pend      = r_pend;
        n_wrk       = r_wrk;
        n_bc_left   = r_bc_left;
        n_bc_kind   = r_bc_kind;
        mem_we      = 1'b0;
        o_cmd_ready = 1'b0;
        o_res_valid = 1'b0;
        o_res.kind  = KIND_ROUTE;
        o_res.dest  = '0;
        o_res.handle = '0;
        o_res.last  = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    unique case (i_cmd.op)
                        OP_CREDIT: begin
                            o_cmd_ready = 1'b1;
                            if (!q_full) begin
                                mem_we  = 1'b1;
                                n_tail  = f_inc(r_tail);
                                n_count = r_count + 1'b1;
                            end
                            if (fresh) begin
                                n_mask[widx] = 1'b1;
                            end
                            n_pend = {fresh && r_term, fresh && r_stop, q_full};
                            n_wrk  = i_cmd.worker;
                            if (n_pend != 3'b000) begin
                                n_state = ST_CREDIT;
                            end
                        end
                        OP_EVENT: begin
                            if (i_res_ready) begin
                                o_cmd_ready  = 1'b1;
                                o_res_valid  = 1'b1;
                                o_res.handle = i_cmd.handle;
                                o_res.last   = 1'b1;
                                priority if (i_lax && r_count == '0) begin
                                    o_res.kind = KIND_DISMISS_IDLE;
                                end else if (r_stop) begin
                                    o_res.kind = KIND_DISMISS_STOP;
                                end else if (r_count == '0) begin
                                    o_res.kind = KIND_ERR_IDLE;
                                end else begin
                                    o_res.kind = KIND_ROUTE;
                                    o_res.dest = head_data;
                                    n_head     = f_inc(r_head);
                                    n_count    = r_count - 1'b1;
                                end
                            end
                        end
                        OP_STOP: begin
                            o_cmd_ready = 1'b1;
                            n_stop      = 1'b1;
                            n_bc_left   = r_mask;
                            n_bc_kind   = KIND_STOP;
                            if (r_mask != '0) begin
                                n_state = ST_BCAST;
                            end
                        end
                        OP_TERM: begin
                            o_cmd_ready = 1'b1;
                            n_term      = 1'b1;
                            n_bc_left   = r_mask;
                            n_bc_kind   = KIND_TERM;
                            if (r_mask != '0) begin
                                n_state = ST_BCAST;
                            end
                        end
                        OP_CLEAR: begin
                            o_cmd_ready = 1'b1;
                            n_stop      = 1'b0;
                            n_term      = 1'b0;
                        end
                        default: begin
                            o_cmd_ready = 1'b1;
                        end
                    endcase
                end
            end
            ST_CREDIT: begin
                if (i_res_ready) begin
                    o_res_valid = 1'b1;
                    o_res.dest  = r_wrk;
                    priority if (r_pend[0]) begin
                        o_res.kind = KIND_OVERFLOW;
                        n_pend[0]  = 1'b0;
                    end else if (r_pend[1]) begin
                        o_res.kind = KIND_STOP;
                        n_pend[1]  = 1'b0;
                    end else begin
                        o_res.kind = KIND_TERM;
                        n_pend[2]  = 1'b0;
                    end
                    o_res.last = (n_pend == 3'b000);
                    if (o_res.last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_BCAST: begin
                if (i_res_ready) begin
                    o_res_valid       = 1'b1;
                    o_res.kind        = r_bc_kind;
                    o_res.dest        = WORKER_W'(bc_idx);
                    n_bc_left[bc_idx] = 1'b0;
                    o_res.last        = (n_bc_left == '0);
                    if (o_res.last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // Ready status as it stands after this item
        o_res.can_accept = i_lax || (n_count != '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_mask      <= '0;
            r_stop      <= 1'b0;
            r_term      <= 1'b0;
            r_pend      <= 3'b000;
            r_byp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
            r_mask      <= n_mask;
            r_stop      <= n_stop;
            r_term      <= n_term;
            r_pend      <= n_pend;
            // A write landing on the next head slot is forwarded
            r_byp_valid <= mem_we && (r_tail == n_head);
        end
    end

    always_ff @(posedge i_clk) begin
        r_wrk     <= n_wrk;
        r_bc_left <= n_bc_left;
        r_bc_kind <= n_bc_kind;
    end

    // Ready-worker memory: one write port at the tail, head read registered
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_tail] <= i_cmd.worker;
        end
        r_rd_data  <= r_mem[n_head];
        r_byp_data <= i_cmd.worker;
    end

endmodule

### rtl/cld_resq.sv
// ============================================================================
// cld_resq
// Two-entry result queue between the back end and the result ports.
// ============================================================================
module cld_resq (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  cld_pkg::t_res i_res,
    input  logic          i_res_valid,
    output logic          o_res_ready,
    output cld_pkg::t_res o_res,
    output logic          o_empty,
    input  logic          i_pop
);
    import cld_pkg::*;

    t_res       r_q [2];
    logic       r_wr, n_wr;
    logic       r_rd, n_rd;
    logic [1:0] r_cnt, n_cnt;
    logic       do_wr;
    logic       do_rd;

    assign o_res_ready = (r_cnt != 2'd2);
    assign o_empty     = (r_cnt == 2'd0);
    assign o_res       = r_q[r_rd];

    always_comb begin
        do_wr = i_res_valid && o_res_ready;
        do_rd = i_pop && !o_empty;
        n_wr  = do_wr ? !r_wr : r_wr;
        n_rd  = do_rd ? !r_rd : r_rd;
        n_cnt = r_cnt + 2'(do_wr) - 2'(do_rd);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_q[r_wr] <= i_res;
        end
    end

endmodule

### rtl/credit_load_balancer_dispatch_top.sv
// ============================================================================
// credit_load_balancer_dispatch_top
// Credit-based work dispatcher: routes events to ready workers.
//
//  Channel   Handshake             Fields
//  --------  --------------------  --------------------------------------------
//  input     push / full           i_action, i_worker, i_event_handle
//  result    pop / empty           o_kind, o_dest_worker, o_routed_handle,
//                                  o_can_accept, o_last
//  config    APB psel/penable      lax at byte address 0
//
//  Credits and events run at one item per cycle while the result queue has room
//  and no credit or broadcast results are pending. An event's result passes
//  through the command and result queues; a credit or broadcast issues its
//  results from ST_CREDIT or ST_BCAST, which holds the executor until one
//  message per result or per registered worker has gone out. Reset is
//  synchronous; no clearing pass is needed. full and empty stall each side
//  through the command and result queues; a held result side backs up to full.
// ============================================================================
module credit_load_balancer_dispatch_top #(
    parameter int NUM_WORKERS = cld_pkg::NUM_WORKERS_DEF,
    parameter int QUEUE_DEPTH = cld_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         push,
    output logic                         full,
    input  logic [cld_pkg::ACTION_W-1:0] i_action,
    input  logic [cld_pkg::WORKER_W-1:0] i_worker,
    input  logic [cld_pkg::HANDLE_W-1:0] i_event_handle,
    output logic                         empty,
    input  logic                         pop,
    output logic [2:0]                   o_kind,
    output logic [cld_pkg::WORKER_W-1:0] o_dest_worker,
    output logic [cld_pkg::HANDLE_W-1:0] o_routed_handle,
    output logic                         o_can_accept,
    output logic                         o_last,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [cld_pkg::ADDR_W-1:0]   paddr,
    input  logic [cld_pkg::DATA_W-1:0]   pwdata,
    output logic [cld_pkg::DATA_W-1:0]   prdata,
    output logic                         pready
);
    import cld_pkg::*;

    logic r_lax;
    t_cmd cmd;
    logic cmd_valid;
    logic cmd_ready;
    t_res res_in;
    logic res_in_valid;
    logic res_in_ready;
    t_res res_out;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_LAX) ? DATA_W'(r_lax) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lax <= 1'b0;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_LAX) begin
            r_lax <= pwdata[0];
        end
    end

    cld_front #(
        .NUM_WORKERS (NUM_WORKERS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push),
        .o_full         (full),
        .i_action       (i_action),
        .i_worker       (i_worker),
        .i_event_handle (i_event_handle),
        .o_cmd          (cmd),
        .o_cmd_valid    (cmd_valid),
        .i_cmd_ready    (cmd_ready)
    );

    cld_back #(
        .NUM_WORKERS (NUM_WORKERS),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_cmd_valid (cmd_valid),
        .o_cmd_ready (cmd_ready),
        .i_lax       (r_lax),
        .o_res       (res_in),
        .o_res_valid (res_in_valid),
        .i_res_ready (res_in_ready)
    );

    cld_resq u_resq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res       (res_in),
        .i_res_valid (res_in_valid),
        .o_res_ready (res_in_ready),
        .o_res       (res_out),
        .o_empty     (empty),
        .i_pop       (pop)
    );

    assign o_kind          = res_out.kind;
    assign o_dest_worker   = res_out.dest;
    assign o_routed_handle = res_out.handle;
    assign o_can_accept    = res_out.can_accept;
    assign o_last          = res_out.last;

endmodule

### rtl/cld_checker.sv
// ============================================================================
// cld_checker
// Port-level checks of the dispatcher, bound to the top level.
// ============================================================================
module cld_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         full,
    input logic                         empty,
    input logic                         pop,
    input logic [2:0]                   o_kind,
    input logic [cld_pkg::WORKER_W-1:0] o_dest_worker,
    input logic [cld_pkg::HANDLE_W-1:0] o_routed_handle,
    input logic                         o_last
);
    import cld_pkg::*;

    // Both queues come out of reset empty
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("queues not empty after reset");

    // Event outcomes other than routing carry no destination
    a_dismiss_dest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (o_kind == KIND_DISMISS_IDLE || o_kind == KIND_DISMISS_STOP ||
                    o_kind == KIND_ERR_IDLE))
        |-> (o_dest_worker == '0))
        else $error("dismissed item with nonzero destination");

    // Control messages and overflow carry no handle
    a_ctrl_handle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (o_kind == KIND_STOP || o_kind == KIND_TERM ||
                    o_kind == KIND_OVERFLOW))
        |-> (o_routed_handle == '0))
        else $error("control result with nonzero handle");

    // Every event yields exactly one result, so event kinds always end the item
    a_event_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (o_kind == KIND_ROUTE || o_kind == KIND_DISMISS_IDLE ||
                    o_kind == KIND_DISMISS_STOP || o_kind == KIND_ERR_IDLE))
        |-> o_last)
        else $error("event result without last");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_kind) && $stable(o_dest_worker) &&
                              $stable(o_routed_handle)))
        else $error("stalled result changed");

endmodule

bind credit_load_balancer_dispatch_top cld_checker u_cld_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .full            (full),
    .empty           (empty),
    .pop             (pop),
    .o_kind          (o_kind),
    .o_dest_worker   (o_dest_worker),
    .o_routed_handle (o_routed_handle),
    .o_last          (o_last)
);

### verif/testbench.sv
`timescale 1ns / 1ps
// ============================================================================
// testbench
// Runs credits, events and control commands through the dispatcher. Each
// accepted item is predicted in step, and every result is checked in order.
// The lax register is written between phases. One phase holds off the result
// side long enough to back the block up into its input.
// ============================================================================
module testbench;
    import cld_pkg::*;

    localparam int NUM_WORKERS = NUM_WORKERS_DEF;
    localparam int QUEUE_DEPTH = QUEUE_DEPTH_DEF;

    // actions the block must ignore
    localparam logic [ACTION_W-1:0] ACT_RSVD_LO = 3'd5;
    localparam logic [ACTION_W-1:0] ACT_RSVD_HI = 3'd7;

    localparam logic [ADDR_W-1:0] ADDR_LAX = {REG_LAX, 2'b00};

    localparam int MIX_BALANCED = 0;
    localparam int MIX_CREDITS  = 1;
    localparam int MIX_EVENTS   = 2;

    localparam int SETTLE_CYCLES = 64;
    localparam int HOLD_CYCLES   = 400;

    typedef struct {
        logic [ACTION_W-1:0] action;
        logic [WORKER_W-1:0] worker;
        logic [HANDLE_W-1:0] handle;
    } t_work_item;

    logic                i_clk          = 1'b0;
    logic                i_rst_n        = 1'b0;
    logic                push           = 1'b0;
    logic                full;
    logic [ACTION_W-1:0] i_action       = '0;
    logic [WORKER_W-1:0] i_worker       = '0;
    logic [HANDLE_W-1:0] i_event_handle = '0;
    logic                empty;
    logic                pop            = 1'b0;
    logic [2:0]          o_kind;
    logic [WORKER_W-1:0] o_dest_worker;
    logic [HANDLE_W-1:0] o_routed_handle;
    logic                o_can_accept;
    logic                o_last;
    logic                psel           = 1'b0;
    logic                penable        = 1'b0;
    logic                pwrite         = 1'b0;
    logic [ADDR_W-1:0]   paddr          = '0;
    logic [DATA_W-1:0]   pwdata         = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    // stimulus, predicted results and dispatcher state copy
    t_work_item          items_to_send[$];
    t_res                expected_results[$];
    logic [WORKER_W-1:0] ready_workers[$];
    logic [NUM_WORKERS-1:0] known_workers = '0;
    logic                stop_flag = 1'b0;
    logic                term_flag = 1'b0;
    logic                lax_cfg   = 1'b0;

    int   err_cnt     = 0;
    logic in_taken    = 1'b0;
    bit   tx_calm     = 1'b0;
    bit   rx_calm     = 1'b0;
    int   tx_gap      = 0;
    int   rx_gap      = 0;
    int   hold_left   = 0;
    int   hold_req    = 0;
    int   hold_served = 0;

    credit_load_balancer_dispatch_top u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .push            (push),
        .full            (full),
        .i_action        (i_action),
        .i_worker        (i_worker),
        .i_event_handle  (i_event_handle),
        .empty           (empty),
        .pop             (pop),
        .o_kind          (o_kind),
        .o_dest_worker   (o_dest_worker),
        .o_routed_handle (o_routed_handle),
        .o_can_accept    (o_can_accept),
        .o_last          (o_last),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #10_000_000;
        $display("testbench: FAIL");
        $finish;
    end

    function automatic int pick_gap(bit calm);
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic t_res make_res(t_kind k, logic [WORKER_W-1:0] d,
                                      logic [HANDLE_W-1:0] h);
        t_res r;
        r.kind       = k;
        r.dest       = d;
        r.handle     = h;
        r.can_accept = 1'b0;
        r.last       = 1'b0;
        return r;
    endfunction

    task automatic predict_dispatch(input t_work_item it);
        t_res                outs[$];
        t_kind               bk;
        logic [WORKER_W-1:0] dw;
        case (it.action)
            ACT_CREDIT: begin
                if (it.worker < NUM_WORKERS) begin
                    if (ready_workers.size() < QUEUE_DEPTH)
                        ready_workers.insert(ready_workers.size(), it.worker);
                    else
                        outs.insert(outs.size(), make_res(KIND_OVERFLOW, it.worker, '0));
                    // first credit from a worker: replay any sticky command
                    if (!known_workers[it.worker]) begin
                        known_workers[it.worker] = 1'b1;
                        if (stop_flag)
                            outs.insert(outs.size(), make_res(KIND_STOP, it.worker, '0));
                        if (term_flag)
                            outs.insert(outs.size(), make_res(KIND_TERM, it.worker, '0));
                    end
                end
            end
            ACT_EVENT: begin
                // lax with nobody ready wins over the stop check
                if (lax_cfg && ready_workers.size() == 0)
                    outs.insert(outs.size(), make_res(KIND_DISMISS_IDLE, '0, it.handle));
                else if (stop_flag)
                    outs.insert(outs.size(), make_res(KIND_DISMISS_STOP, '0, it.handle));
                else if (ready_workers.size() == 0)
                    outs.insert(outs.size(), make_res(KIND_ERR_IDLE, '0, it.handle));
                else begin
                    dw = ready_workers[0];
                    ready_workers.delete(0);
                    outs.insert(outs.size(), make_res(KIND_ROUTE, dw, it.handle));
                end
            end
            ACT_STOP, ACT_TERM: begin
                bk = (it.action == ACT_STOP) ? KIND_STOP : KIND_TERM;
                for (int w = 0; w < NUM_WORKERS; w++)
                    if (known_workers[w])
                        outs.insert(outs.size(), make_res(bk, WORKER_W'(w), '0));
                if (it.action == ACT_STOP)
                    stop_flag = 1'b1;
                else
                    term_flag = 1'b1;
            end
            ACT_CLEAR: begin
                stop_flag = 1'b0;
                term_flag = 1'b0;
            end
            default: ;
        endcase
        foreach (outs[i]) begin
            outs[i].can_accept = lax_cfg || (ready_workers.size() > 0);
            outs[i].last       = (i == outs.size() - 1);
            expected_results.insert(expected_results.size(), outs[i]);
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] expv,
                               input logic [31:0] actv);
        if (expv !== actv) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                     $time, name, expv, actv);
            err_cnt++;
        end
    endtask

    // input acceptance, prediction and result checking
    always @(posedge i_clk) begin
        t_work_item taken;
        t_res       exp_r;
        in_taken <= i_rst_n && push && !full;
        if (i_rst_n && push && !full) begin
            taken.action = i_action;
            taken.worker = i_worker;
            taken.handle = i_event_handle;
            predict_dispatch(taken);
        end
        if (i_rst_n && pop && !empty) begin
            if (expected_results.size() == 0) begin
                $display("%0t ns: result with none expected: kind %0d dest %0d handle %h",
                         $time, o_kind, o_dest_worker, o_routed_handle);
                err_cnt++;
            end else begin
                exp_r = expected_results[0];
                expected_results.delete(0);
                check_field("kind", 32'(exp_r.kind), 32'(o_kind));
                check_field("dest_worker", 32'(exp_r.dest), 32'(o_dest_worker));
                check_field("routed_handle", 32'(exp_r.handle), 32'(o_routed_handle));
                check_field("can_accept", 32'(exp_r.can_accept), 32'(o_can_accept));
                check_field("last", 32'(exp_r.last), 32'(o_last));
            end
        end
    end

    // item sender
    always @(negedge i_clk) begin
        t_work_item it;
        if (i_rst_n && !(push && !in_taken)) begin
            if (tx_gap > 0) begin
                tx_gap--;
                push <= 1'b0;
            end else if (items_to_send.size() > 0) begin
                it = items_to_send[0];
                items_to_send.delete(0);
                i_action       <= it.action;
                i_worker       <= it.worker;
                i_event_handle <= it.handle;
                push           <= 1'b1;
                tx_gap = pick_gap(tx_calm);
            end else begin
                push <= 1'b0;
            end
        end
    end

    // result receiver
    always @(negedge i_clk) begin
        if (hold_req != hold_served) begin
            hold_served = hold_req;
            hold_left   = HOLD_CYCLES;
        end
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            pop <= 1'b0;
        end else if (rx_gap > 0) begin
            rx_gap--;
            pop <= 1'b0;
        end else begin
            pop <= 1'b1;
            rx_gap = pick_gap(rx_calm);
        end
    end

    task automatic queue_item(input logic [ACTION_W-1:0] a, input logic [WORKER_W-1:0] w,
                              input logic [HANDLE_W-1:0] h);
        t_work_item it;
        it.action = a;
        it.worker = w;
        it.handle = h;
        items_to_send.insert(items_to_send.size(), it);
    endtask

    function automatic t_work_item random_item(int mix);
        t_work_item it;
        int r;
        int c_th;
        int e_th;
        c_th = (mix == MIX_CREDITS) ? 75 : (mix == MIX_EVENTS) ? 15 : 42;
        e_th = (mix == MIX_CREDITS) ? 91 : (mix == MIX_EVENTS) ? 92 : 86;
        r = $urandom_range(0, 99);
        it.worker = WORKER_W'($urandom_range(0, NUM_WORKERS - 1));
        it.handle = 16'($urandom);
        if (r < c_th)
            it.action = ACT_CREDIT;
        else if (r < e_th)
            it.action = ACT_EVENT;
        else if (r < e_th + 3)
            it.action = ACT_STOP;
        else if (r < e_th + 5)
            it.action = ACT_TERM;
        else if (r < e_th + 9)
            it.action = ACT_CLEAR;
        else
            it.action = ACTION_W'($urandom_range(ACT_RSVD_LO, ACT_RSVD_HI));
        return it;
    endfunction

    // everything sent and checked, then let no-result items drain
    task automatic wait_idle();
        do
            @(posedge i_clk);
        while (items_to_send.size() != 0 || push || expected_results.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_lax(input logic v);
        logic [DATA_W-1:0] wdata;
        wdata    = $urandom;
        wdata[0] = v;
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_LAX;
        pwdata  <= wdata;
        @(negedge i_clk);
        penable <= 1'b1;
        do
            @(posedge i_clk);
        while (!pready);
        lax_cfg = v;
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do
            @(posedge i_clk);
        while (!pready);
        if (prdata[0] !== v) begin
            $display("%0t ns: lax readback mismatch, expected %0d, actual %0d",
                     $time, v, prdata[0]);
            err_cnt++;
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    initial begin
        int                  n;
        int                  mix;
        logic [WORKER_W-1:0] w;

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // strict mode: errors, broadcasts with and without workers, late joiners
        queue_item(ACT_EVENT, 4'd0, 16'hFFFF);
        queue_item(ACT_STOP, 4'd0, 16'h0000);
        queue_item(ACT_TERM, 4'd0, 16'h0000);
        queue_item(ACT_CREDIT, 4'd0, 16'h0000);
        queue_item(ACT_CREDIT, 4'd15, 16'hFFFF);
        queue_item(ACT_EVENT, 4'd0, 16'h1234);
        queue_item(ACT_CLEAR, 4'd0, 16'h0000);
        queue_item(ACT_CREDIT, 4'd0, 16'h0000);
        queue_item(ACT_EVENT, 4'd0, 16'h0000);
        queue_item(ACT_EVENT, 4'd15, 16'hFFFF);
        queue_item(ACT_EVENT, 4'd0, 16'h0001);
        queue_item(ACT_EVENT, 4'd0, 16'h8000);
        queue_item(ACT_STOP, 4'd0, 16'h0000);
        queue_item(ACT_TERM, 4'd0, 16'h0000);
        queue_item(ACT_CLEAR, 4'd0, 16'h0000);
        queue_item(ACT_RSVD_LO, 4'd15, 16'hFFFF);
        queue_item(ACT_RSVD_LO + 3'd1, 4'd15, 16'hFFFF);
        queue_item(ACT_RSVD_HI, 4'd15, 16'hFFFF);
        wait_idle();

        // lax mode: idle dismiss ahead of stop dismiss
        set_lax(1'b1);
        queue_item(ACT_EVENT, 4'd0, 16'hAAAA);
        queue_item(ACT_STOP, 4'd0, 16'h0000);
        queue_item(ACT_EVENT, 4'd0, 16'h5555);
        queue_item(ACT_CREDIT, 4'd3, 16'h0000);
        queue_item(ACT_EVENT, 4'd0, 16'h0F0F);
        queue_item(ACT_CLEAR, 4'd0, 16'h0000);
        queue_item(ACT_EVENT, 4'd0, 16'hF0F0);
        wait_idle();

        // overfill the ready queue from known workers, then a new worker
        // joins while full after stop and terminate
        set_lax(1'b0);
        for (int k = 0; k < 70; k++) begin
            case ($urandom_range(0, 2))
                0: w = 4'd0;
                1: w = 4'd3;
                default: w = 4'd15;
            endcase
            queue_item(ACT_CREDIT, w, 16'($urandom));
        end
        queue_item(ACT_STOP, 4'd0, 16'($urandom));
        queue_item(ACT_TERM, 4'd0, 16'($urandom));
        queue_item(ACT_CREDIT, 4'd9, 16'($urandom));
        queue_item(ACT_CLEAR, 4'd0, 16'($urandom));
        for (int k = 0; k < 66; k++)
            queue_item(ACT_EVENT, 4'($urandom), 16'($urandom));
        wait_idle();

        for (int p = 0; p < 6; p++) begin
            set_lax(1'(p % 2));
            tx_calm = (p == 1) || ($urandom_range(0, 3) == 0);
            rx_calm = (p == 3);
            n   = (p == 1) ? 100 : 45;
            mix = (p == 1 || p == 4) ? MIX_EVENTS : (p == 2) ? MIX_CREDITS : MIX_BALANCED;
            for (int k = 0; k < n; k++)
                items_to_send.insert(items_to_send.size(), random_item(mix));
            // long receiver stall while the sender keeps offering
            if (p == 1)
                hold_req++;
            wait_idle();
        end

        if (err_cnt == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
